>>> hw/rtl/i2cseq_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// Used by the controller, the datapath and the top level.
// No dependencies.
package i2cseq_pkg;

  // The byte buffer depth must be a power of two: the transfer position wraps into it by masking.
  localparam int unsigned BufferDepth = 256;
  localparam int unsigned BufAw       = $clog2(BufferDepth);
  localparam int unsigned PosW        = 9;

  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_EVENT  = 2'd1,
    OP_BUF_WR = 2'd2,
    OP_BUF_RD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TX    = 3'd3,
    PH_RX    = 3'd4,
    PH_ACK   = 3'd5,
    PH_STOP  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HW      = 2'd1,
    ERR_OVERRUN = 2'd2,
    ERR_NOT_ACK = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CTL_WAIT = 2'd0,
    CTL_EXEC = 2'd1,
    CTL_OUT  = 2'd2
  } ctl_state_e;

  typedef enum logic [1:0] {
    CB_ZERO = 2'd0,
    CB_ADDR = 2'd1,
    CB_MEM  = 2'd2
  } cbyte_sel_e;

  typedef enum logic {
    WA_INDEX = 1'b0,
    WA_POS   = 1'b1
  } waddr_sel_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] address_byte;
    logic [7:0] length;
    logic [7:0] index;
    logic [7:0] data;
    logic       engine_busy;
    logic       ack_status;
    logic       buffer_full;
    logic       write_collision;
    logic       overrun;
  } req_t;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] command_byte;
    logic       ack_bit;
    err_e       error;
    logic       idle;
    logic [7:0] read_data;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;
    logic       load_start;
    logic       pos_inc;
    logic       mem_we;
    waddr_sel_e waddr_sel;
    logic       out_load;
    cmd_e       command;
    cbyte_sel_e cbyte_sel;
    logic       ack_bit;
    err_e       error;
    logic       idle;
    logic       rdata_en;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic read_xfer;
    logic busy;
    logic nack;
    logic full;
    logic wcol;
    logic ovr;
    logic at_end;
    logic at_end_next;
    logic idx_ok;
  } dp_stat_t;

endpackage

>>> hw/rtl/i2cseq_req_if.sv
// Request channel of the I2C master transfer sequencer: valid, ready and one input word.
// Depends on nothing.
interface i2cseq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] address_byte;
  logic [7:0] length;
  logic [7:0] index;
  logic [7:0] data;
  logic       engine_busy;
  logic       ack_status;
  logic       buffer_full;
  logic       write_collision;
  logic       overrun;

  modport source (
    output valid, op, address_byte, length, index, data,
    output engine_busy, ack_status, buffer_full, write_collision, overrun,
    input  ready
  );

  modport sink (
    input  valid, op, address_byte, length, index, data,
    input  engine_busy, ack_status, buffer_full, write_collision, overrun,
    output ready
  );
endinterface

>>> hw/rtl/i2cseq_rsp_if.sv
// Response channel of the I2C master transfer sequencer: valid, ready and one result word.
// Depends on nothing.
interface i2cseq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] command_byte;
  logic       ack_bit;
  logic [1:0] error;
  logic       idle;
  logic [7:0] read_data;

  modport source (
    output valid, command, command_byte, ack_bit, error, idle, read_data,
    input  ready
  );

  modport sink (
    input  valid, command, command_byte, ack_bit, error, idle, read_data,
    output ready
  );
endinterface

>>> hw/rtl/i2c_master_transfer_sequencer_core.sv
// Top level of the I2C master transfer sequencer: controller plus datapath behind
// valid/ready request and response channels. Depends on i2cseq_pkg and both interfaces.
//
// Every request word gives exactly one response word, and one word is in flight at a time.
// A word passes through the controller states wait, exec and out in turn. In the wait state
// it is accepted; that edge registers the word and reads the byte buffer. The exec state is
// the decision step that updates the transfer phase, position and buffer and loads the
// response register. In the out state the response is valid; it is
// held until the sink takes it. The next request word is accepted in the cycle after the
// response is taken, so the block takes no new word until the last response has been taken.
// The 256-byte buffer is a memory with a registered read and is not cleared by reset;
// a buffer entry must be written (by a buffer write or a received byte) before it is read.
module i2c_master_transfer_sequencer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cseq_req_if.sink    req_i,
  i2cseq_rsp_if.source  rsp_o
);
  import i2cseq_pkg::*;

  req_t     req_pl;
  rsp_t     rsp_pl;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign req_pl.op              = op_e'(req_i.op);
  assign req_pl.address_byte    = req_i.address_byte;
  assign req_pl.length          = req_i.length;
  assign req_pl.index           = req_i.index;
  assign req_pl.data            = req_i.data;
  assign req_pl.engine_busy     = req_i.engine_busy;
  assign req_pl.ack_status      = req_i.ack_status;
  assign req_pl.buffer_full     = req_i.buffer_full;
  assign req_pl.write_collision = req_i.write_collision;
  assign req_pl.overrun         = req_i.overrun;

  i2cseq_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  i2cseq_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_pl),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat),
    .rsp_o  (rsp_pl)
  );

  assign rsp_o.command      = rsp_pl.command;
  assign rsp_o.command_byte = rsp_pl.command_byte;
  assign rsp_o.ack_bit      = rsp_pl.ack_bit;
  assign rsp_o.error        = rsp_pl.error;
  assign rsp_o.idle         = rsp_pl.idle;
  assign rsp_o.read_data    = rsp_pl.read_data;

endmodule

>>> hw/rtl/i2cseq_datapath.sv
// Datapath of the I2C master transfer sequencer: input word register, transfer registers,
// byte buffer memory and result register. Depends on i2cseq_pkg.
module i2cseq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cseq_pkg::req_t    req_i,
  input  i2cseq_pkg::dp_cmd_t cmd_i,
  output i2cseq_pkg::dp_stat_t stat_o,
  output i2cseq_pkg::rsp_t    rsp_o
);
  import i2cseq_pkg::*;

  req_t            item_q;
  rsp_t            rsp_q;
  logic [7:0]      slave_addr_q, slave_addr_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] end_q, end_d;
  logic [PosW-1:0] pos_next;
  logic [7:0]      mem_q [BufferDepth];
  logic [7:0]      rd_q;
  logic [BufAw-1:0] raddr;
  logic [BufAw-1:0] waddr;
  logic [7:0]      cbyte;

  assign pos_next = pos_q + PosW'(1);

  // The read is issued on the accept edge, so the buffer byte is ready for the decision cycle.
  assign raddr = (req_i.op == OP_BUF_RD) ? req_i.index[BufAw-1:0] : pos_q[BufAw-1:0];
  assign waddr = (cmd_i.waddr_sel == WA_POS) ? pos_q[BufAw-1:0] : item_q.index[BufAw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= req_i;
      rd_q   <= mem_q[raddr];
    end
    if (cmd_i.mem_we) begin
      mem_q[waddr] <= item_q.data;
    end
  end

  always_comb begin
    slave_addr_d = slave_addr_q;
    pos_d        = pos_q;
    end_d        = end_q;
    if (cmd_i.load_start) begin
      slave_addr_d = item_q.address_byte;
      pos_d        = '0;
      end_d        = {1'b0, item_q.length};
    end else if (cmd_i.pos_inc) begin
      pos_d = pos_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      pos_q        <= '0;
      end_q        <= '0;
    end else begin
      slave_addr_q <= slave_addr_d;
      pos_q        <= pos_d;
      end_q        <= end_d;
    end
  end

  always_comb begin
    case (cmd_i.cbyte_sel)
      CB_ADDR: cbyte = slave_addr_q;
      CB_MEM:  cbyte = rd_q;
      default: cbyte = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.command      <= cmd_i.command;
      rsp_q.command_byte <= cbyte;
      rsp_q.ack_bit      <= cmd_i.ack_bit;
      rsp_q.error        <= cmd_i.error;
      rsp_q.idle         <= cmd_i.idle;
      rsp_q.read_data    <= cmd_i.rdata_en ? rd_q : 8'h00;
    end
  end

  assign rsp_o = rsp_q;

  assign stat_o.op          = item_q.op;
  assign stat_o.read_xfer   = (slave_addr_q & ReadBit) != 8'h00;
  assign stat_o.busy        = item_q.engine_busy;
  assign stat_o.nack        = item_q.ack_status;
  assign stat_o.full        = item_q.buffer_full;
  assign stat_o.wcol        = item_q.write_collision;
  assign stat_o.ovr         = item_q.overrun;
  assign stat_o.at_end      = pos_q >= end_q;
  assign stat_o.at_end_next = pos_next >= end_q;
  assign stat_o.idx_ok      = {1'b0, item_q.index} < PosW'(BufferDepth);

endmodule

>>> hw/rtl/i2cseq_controller.sv
// Controller of the I2C master transfer sequencer: handshake sequencing and the bus
// transfer phase machine. Depends on i2cseq_pkg.
module i2cseq_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  input  i2cseq_pkg::dp_stat_t stat_i,
  output i2cseq_pkg::dp_cmd_t  cmd_o
);
  import i2cseq_pkg::*;

  ctl_state_e state_q, state_d;
  phase_e     phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_WAIT;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    unique case (state_q)
      CTL_WAIT: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTL_EXEC;
        end
      end

      CTL_EXEC: begin
        cmd_o.out_load = 1'b1;
        state_d        = CTL_OUT;
        case (stat_i.op)
          OP_START: begin
            if (stat_i.busy || phase_q != PH_IDLE) begin
              cmd_o.error = ERR_HW;
            end else begin
              cmd_o.load_start = 1'b1;
              cmd_o.command    = CMD_START;
              phase_d          = PH_START;
            end
          end

          OP_EVENT: begin
            if (phase_q != PH_IDLE) begin
              if (stat_i.wcol) begin
                cmd_o.error = ERR_HW;
              end else if (stat_i.ovr) begin
                cmd_o.error = ERR_OVERRUN;
              end else begin
                unique case (phase_q)
                  PH_START: begin
                    cmd_o.command   = CMD_WRITE;
                    cmd_o.cbyte_sel = CB_ADDR;
                    phase_d         = PH_ADDR;
                  end
                  PH_ADDR: begin
                    if (stat_i.nack) begin
                      cmd_o.error = ERR_HW;
                    end else if (stat_i.read_xfer) begin
                      cmd_o.command = CMD_RECV;
                      phase_d       = PH_RX;
                    end else begin
                      cmd_o.command   = CMD_WRITE;
                      cmd_o.cbyte_sel = CB_MEM;
                      cmd_o.pos_inc   = 1'b1;
                      phase_d         = PH_TX;
                    end
                  end
                  PH_RX: begin
                    if (!stat_i.full) begin
                      cmd_o.error = ERR_OVERRUN;
                    end else begin
                      // The last-byte test looks at the position after this byte.
                      cmd_o.mem_we    = 1'b1;
                      cmd_o.waddr_sel = WA_POS;
                      cmd_o.pos_inc   = 1'b1;
                      cmd_o.command   = CMD_ACK;
                      cmd_o.ack_bit   = stat_i.at_end_next;
                      phase_d         = PH_ACK;
                    end
                  end
                  PH_TX: begin
                    if (stat_i.nack) begin
                      cmd_o.error = ERR_NOT_ACK;
                    end else if (stat_i.at_end) begin
                      cmd_o.command = CMD_STOP;
                      phase_d       = PH_STOP;
                    end else begin
                      cmd_o.command   = CMD_WRITE;
                      cmd_o.cbyte_sel = CB_MEM;
                      cmd_o.pos_inc   = 1'b1;
                    end
                  end
                  PH_ACK: begin
                    if (stat_i.at_end) begin
                      cmd_o.command = CMD_STOP;
                      phase_d       = PH_STOP;
                    end else begin
                      cmd_o.command = CMD_RECV;
                      phase_d       = PH_RX;
                    end
                  end
                  default: begin
                    // The event after a stop ends the transfer.
                    phase_d = PH_IDLE;
                  end
                endcase
              end
            end
          end

          OP_BUF_WR: begin
            cmd_o.mem_we    = stat_i.idx_ok;
            cmd_o.waddr_sel = WA_INDEX;
          end

          default: begin
            cmd_o.rdata_en = stat_i.idx_ok;
          end
        endcase

        if (cmd_o.error != ERR_NONE) begin
          cmd_o.command   = CMD_NONE;
          cmd_o.cbyte_sel = CB_ZERO;
          cmd_o.ack_bit   = 1'b0;
          phase_d         = PH_IDLE;
        end
        cmd_o.idle = (phase_d == PH_IDLE);
      end

      CTL_OUT: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = CTL_WAIT;
        end
      end

      default: begin
        state_d = CTL_WAIT;
      end
    endcase
  end

  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("word accepted while a result is pending");

  a_exec_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CTL_EXEC |=> state_q == CTL_OUT && rsp_valid_o)
    else $error("decision cycle not followed by a result");

  a_error_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_EXEC && cmd_o.error != ERR_NONE) |=> phase_q == PH_IDLE)
    else $error("error did not end the transfer");

  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_start |-> (phase_q == PH_IDLE && !stat_i.busy))
    else $error("transfer started while busy");

  a_phase_moves_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != CTL_EXEC |=> $stable(phase_q))
    else $error("phase changed outside the decision cycle");

endmodule

>>> verif/i2cseq_transfer_check.sv
// Checker for the I2C master transfer sequencer: watches both channels, predicts each result
// word and compares it field by field. Depends on i2cseq_pkg and both channel interfaces.
module i2cseq_transfer_check (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cseq_req_if req_i,
  i2cseq_rsp_if rsp_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  phase_e          xfer_phase;
  logic [7:0]      slave_addr;
  logic [PosW-1:0] xfer_pos;
  logic [PosW-1:0] xfer_end;
  logic [7:0]      byte_mem [BufferDepth];
  rsp_t            expected_rsp_q [$];
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Advances the transfer state by one request word and returns the result it calls for.
  task automatic sequence_word(input req_t w, output rsp_t r);
    r = '0;
    case (w.op)
      OP_START: begin
        if (w.engine_busy || xfer_phase != PH_IDLE) begin
          r.error = ERR_HW;
        end else begin
          slave_addr = w.address_byte;
          xfer_pos   = '0;
          xfer_end   = {1'b0, w.length};
          r.command  = CMD_START;
          xfer_phase = PH_START;
        end
      end
      OP_EVENT: begin
        if (xfer_phase != PH_IDLE) begin
          if (w.write_collision) begin
            r.error = ERR_HW;
          end else if (w.overrun) begin
            r.error = ERR_OVERRUN;
          end else begin
            case (xfer_phase)
              PH_START: begin
                r.command      = CMD_WRITE;
                r.command_byte = slave_addr;
                xfer_phase     = PH_ADDR;
              end
              PH_ADDR: begin
                if (w.ack_status) begin
                  r.error = ERR_HW;
                end else if ((slave_addr & ReadBit) != 0) begin
                  r.command  = CMD_RECV;
                  xfer_phase = PH_RX;
                end else begin
                  r.command      = CMD_WRITE;
                  r.command_byte = byte_mem[xfer_pos[BufAw-1:0]];
                  xfer_pos       = xfer_pos + 1'b1;
                  xfer_phase     = PH_TX;
                end
              end
              PH_RX: begin
                if (!w.buffer_full) begin
                  r.error = ERR_OVERRUN;
                end else begin
                  byte_mem[xfer_pos[BufAw-1:0]] = w.data;
                  xfer_pos   = xfer_pos + 1'b1;
                  r.command  = CMD_ACK;
                  r.ack_bit  = (xfer_pos >= xfer_end);
                  xfer_phase = PH_ACK;
                end
              end
              PH_TX: begin
                if (w.ack_status) begin
                  r.error = ERR_NOT_ACK;
                end else if (xfer_pos >= xfer_end) begin
                  r.command  = CMD_STOP;
                  xfer_phase = PH_STOP;
                end else begin
                  r.command      = CMD_WRITE;
                  r.command_byte = byte_mem[xfer_pos[BufAw-1:0]];
                  xfer_pos       = xfer_pos + 1'b1;
                end
              end
              PH_ACK: begin
                if (xfer_pos >= xfer_end) begin
                  r.command  = CMD_STOP;
                  xfer_phase = PH_STOP;
                end else begin
                  r.command  = CMD_RECV;
                  xfer_phase = PH_RX;
                end
              end
              default: xfer_phase = PH_IDLE;
            endcase
          end
        end
      end
      OP_BUF_WR: begin
        if (w.index < BufferDepth) byte_mem[w.index] = w.data;
      end
      default: begin
        if (w.index < BufferDepth) r.read_data = byte_mem[w.index];
      end
    endcase
    if (r.error != ERR_NONE) begin
      r.command      = CMD_NONE;
      r.command_byte = '0;
      r.ack_bit      = 1'b0;
      xfer_phase     = PH_IDLE;
    end
    r.idle = (xfer_phase == PH_IDLE);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got;
    rsp_t want;
    req_t w;
    if (!rst_ni) begin
      xfer_phase = PH_IDLE;
      slave_addr = '0;
      xfer_pos   = '0;
      xfer_end   = '0;
      expected_rsp_q.delete();
      pending_o <= 0;
    end else begin
      // The result channel goes first: a word taken at this edge belongs to an older request.
      if (rsp_i.valid && rsp_i.ready) begin
        got.command      = cmd_e'(rsp_i.command);
        got.command_byte = rsp_i.command_byte;
        got.ack_bit      = rsp_i.ack_bit;
        got.error        = err_e'(rsp_i.error);
        got.idle         = rsp_i.idle;
        got.read_data    = rsp_i.read_data;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result word with none expected, command", int'(got.command), 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.command !== want.command)
            report_mismatch("command", int'(got.command), int'(want.command));
          if (got.command_byte !== want.command_byte)
            report_mismatch("command_byte", int'(got.command_byte), int'(want.command_byte));
          if (got.ack_bit !== want.ack_bit)
            report_mismatch("ack_bit", int'(got.ack_bit), int'(want.ack_bit));
          if (got.error !== want.error)
            report_mismatch("error", int'(got.error), int'(want.error));
          if (got.idle !== want.idle)
            report_mismatch("idle", int'(got.idle), int'(want.idle));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
        end
      end
      if (req_i.valid && req_i.ready) begin
        w.op              = op_e'(req_i.op);
        w.address_byte    = req_i.address_byte;
        w.length          = req_i.length;
        w.index           = req_i.index;
        w.data            = req_i.data;
        w.engine_busy     = req_i.engine_busy;
        w.ack_status      = req_i.ack_status;
        w.buffer_full     = req_i.buffer_full;
        w.write_collision = req_i.write_collision;
        w.overrun         = req_i.overrun;
        sequence_word(w, want);
        expected_rsp_q.push_back(want);
      end
      pending_o <= expected_rsp_q.size();
    end
  end

endmodule

>>> verif/i2c_master_transfer_sequencer_core_test.sv
// Testbench top for the I2C master transfer sequencer: clock, reset, request stimulus and
// result back-pressure, with i2cseq_transfer_check doing the prediction and comparison.
// Depends on i2cseq_pkg, both channel interfaces, the core and the checker.
module i2c_master_transfer_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomWords = 1200;
  localparam int PhaseWords  = 500;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   cycle_count;

  i2cseq_req_if req_if ();
  i2cseq_rsp_if rsp_if ();

  i2c_master_transfer_sequencer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  i2cseq_transfer_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic req_t random_word();
    req_t w;
    w.op              = op_e'($urandom_range(3));
    w.address_byte    = 8'($urandom_range(255));
    w.length          = 8'($urandom_range(255));
    w.index           = 8'($urandom_range(255));
    w.data            = 8'($urandom_range(255));
    w.engine_busy     = 1'($urandom_range(1));
    w.ack_status      = 1'($urandom_range(1));
    w.buffer_full     = 1'($urandom_range(1));
    w.write_collision = 1'($urandom_range(1));
    w.overrun         = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic req_t start_word(input logic [7:0] addr, input logic [7:0] len,
                                      input logic busy);
    req_t w;
    w              = random_word();
    w.op           = OP_START;
    w.address_byte = addr;
    w.length       = len;
    w.engine_busy  = busy;
    return w;
  endfunction

  function automatic req_t event_word(input logic wcol, input logic ovr, input logic nack,
                                      input logic full);
    req_t w;
    w                 = random_word();
    w.op              = OP_EVENT;
    w.write_collision = wcol;
    w.overrun         = ovr;
    w.ack_status      = nack;
    w.buffer_full     = full;
    return w;
  endfunction

  function automatic req_t buffer_word(input op_e op, input logic [7:0] idx,
                                       input logic [7:0] data);
    req_t w;
    w       = random_word();
    w.op    = op;
    w.index = idx;
    w.data  = data;
    return w;
  endfunction

  // Presents one request word at the falling edge and holds it until it is taken.
  task automatic send_word(input req_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.op              <= w.op;
    req_if.address_byte    <= w.address_byte;
    req_if.length          <= w.length;
    req_if.index           <= w.index;
    req_if.data            <= w.data;
    req_if.engine_busy     <= w.engine_busy;
    req_if.ack_status      <= w.ack_status;
    req_if.buffer_full     <= w.buffer_full;
    req_if.write_collision <= w.write_collision;
    req_if.overrun         <= w.overrun;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    words_sent++;
    if (words_sent == PhaseWords) begin
      send_gap_pct   = 57;
      recv_stall_pct = 11;
    end else if (words_sent == 2 * PhaseWords) begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
  endtask

  // One transfer from an idle block: the start word, then the engine events of a clean run,
  // optionally mixed with buffer words and cut short by one fault; the block is idle afterwards.
  task automatic run_transfer(input logic [7:0] addr, input logic [7:0] len,
                              input bit with_fault, input bit with_noise);
    int   n;
    int   steps;
    int   fault_at;
    bit   rd;
    bit   nack_ok;
    bit   full_ok;
    req_t w;
    rd       = ((addr & ReadBit) != 0);
    n        = (len == 0) ? 1 : int'(len);
    steps    = rd ? 2 * n + 3 : n + 3;
    fault_at = with_fault ? int'($urandom_range(steps - 1)) : steps;
    send_word(start_word(addr, len, 1'b0));
    for (int s = 0; s < steps; s++) begin
      if (with_noise && $urandom_range(99) < 8)
        send_word(buffer_word($urandom_range(1) ? OP_BUF_WR : OP_BUF_RD,
                              8'($urandom_range(255)), 8'($urandom_range(255))));
      // Step 1 answers the address byte; a read then alternates receive and acknowledge.
      nack_ok = (s >= 1) && (rd ? (s == 1) : (s <= n + 1));
      full_ok = rd && (s >= 2) && (s <= 2 * n + 1) && (s % 2 == 0);
      if (s == fault_at) begin
        case ($urandom_range(3))
          0: w = event_word(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
          1: w = event_word(1'b0, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
          2: begin
            if (nack_ok) w = event_word(1'b0, 1'b0, 1'b1, 1'b1);
            else if (full_ok) w = event_word(1'b0, 1'b0, 1'b0, 1'b0);
            else w = start_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                                1'($urandom_range(1)));
          end
          default: w = start_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)));
        endcase
        send_word(w);
        break;
      end
      send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    end
  endtask

  initial begin
    logic [7:0] addr;
    logic [7:0] len;
    int         random_base;
    int         scripts;
    int         pick;
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.op              = '0;
    req_if.address_byte    = '0;
    req_if.length          = '0;
    req_if.index           = '0;
    req_if.data            = '0;
    req_if.engine_busy     = 1'b0;
    req_if.ack_status      = 1'b0;
    req_if.buffer_full     = 1'b0;
    req_if.write_collision = 1'b0;
    req_if.overrun         = 1'b0;
    words_sent             = 0;
    send_gap_pct           = 11;
    recv_stall_pct         = 57;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The buffer is not cleared by reset, so every entry gets a byte before anything reads it.
    for (int i = 0; i < BufferDepth; i++)
      send_word(buffer_word(OP_BUF_WR, 8'(i), 8'($urandom_range(255))));

    send_word(buffer_word(OP_BUF_WR, 8'h00, 8'hFF));
    send_word(buffer_word(OP_BUF_WR, 8'hFF, 8'h00));
    send_word(buffer_word(OP_BUF_RD, 8'h00, 8'h00));
    send_word(buffer_word(OP_BUF_RD, 8'hFF, 8'hFF));
    // An event with no transfer open changes nothing, whatever its flags say.
    send_word(event_word(1'b1, 1'b1, 1'b1, 1'b0));
    send_word(start_word(8'hFF, 8'hFF, 1'b1));
    // A zero length still moves one byte.
    run_transfer(8'hFE, 8'h00, 1'b0, 1'b0);
    run_transfer(8'h01, 8'h01, 1'b0, 1'b0);
    // Collision and overrun together: the collision wins.
    send_word(start_word(8'hA4, 8'h03, 1'b0));
    send_word(event_word(1'b1, 1'b1, 1'b0, 1'b1));
    send_word(start_word(8'h5B, 8'h02, 1'b0));
    send_word(event_word(1'b0, 1'b1, 1'b0, 1'b1));
    // The address byte is not acknowledged.
    send_word(start_word(8'h00, 8'h02, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b1));
    // The last data byte is not acknowledged.
    send_word(start_word(8'h3C, 8'h01, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b1, 1'b1));
    // A read finds the receive register not full.
    send_word(start_word(8'hFF, 8'h03, 1'b0));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1));
    send_word(event_word(1'b0, 1'b0, 1'b0, 1'b0));
    // A second start while a transfer is open.
    send_word(start_word(8'h10, 8'h05, 1'b0));
    send_word(start_word(8'h11, 8'h00, 1'b0));

    random_base = words_sent;
    scripts     = 0;
    while (words_sent - random_base < RandomWords) begin
      pick = $urandom_range(99);
      addr = 8'($urandom_range(255));
      if (scripts == 3 || scripts == 7) begin
        // Longest transfers, one write and one read.
        addr[0] = (scripts == 7);
        run_transfer(addr, 8'hFF, 1'b0, 1'b1);
      end else if (pick < 75) begin
        len = ($urandom_range(39) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        run_transfer(addr, len, $urandom_range(99) < 25, 1'b1);
      end else if (pick < 90) begin
        send_word(buffer_word($urandom_range(1) ? OP_BUF_WR : OP_BUF_RD,
                              8'($urandom_range(255)), 8'($urandom_range(255))));
      end else begin
        repeat ($urandom_range(4, 1)) send_word(random_word());
        // A start with the engine busy always leaves the block idle, whatever came before.
        send_word(start_word(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1));
      end
      scripts++;
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> i2c_master_transfer_sequencer_core.f
hw/rtl/i2cseq_pkg.sv
hw/rtl/i2cseq_req_if.sv
hw/rtl/i2cseq_rsp_if.sv
hw/rtl/i2cseq_datapath.sv
hw/rtl/i2cseq_controller.sv
hw/rtl/i2c_master_transfer_sequencer_core.sv
verif/i2cseq_transfer_check.sv
verif/i2c_master_transfer_sequencer_core_test.sv
